// File: rtl/rbst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants of the four-box ray slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int AXES          = 3;
  localparam int REPORTED      = 4;
  localparam int Q_W           = 32;
  localparam int DEF_NUM_BOXES = 4;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_GROW = 2'd1,
    KIND_RAY  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic                   start;
    logic signed [Q_W:0]    num;
    logic signed [Q_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [Q_W-1:0]  q;
  } div_rsp_t;

endpackage

// File: rtl/rbst_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_div
// Bit-serial restoring divider: (num << FRAC_BITS) / den, truncated toward
// zero and saturated to signed 32 bits; one numerator bit per cycle.
// ----------------------------------------------------------------------------
module rbst_div #(
  parameter int FRAC_BITS = rbst_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  rbst_pkg::div_req_t req,
  output rbst_pkg::div_rsp_t rsp
);

  localparam int NB_W  = rbst_pkg::Q_W + 1 + FRAC_BITS;
  localparam int CNT_W = $clog2(NB_W + 1);

  logic [NB_W-1:0]            nsh;
  logic [rbst_pkg::Q_W-1:0]   dmag;
  logic [rbst_pkg::Q_W-1:0]   rem;
  logic [rbst_pkg::Q_W-1:0]   q;
  logic                       ovf;
  logic                       neg;
  logic                       zero;
  logic                       busy;
  logic                       done;
  logic [CNT_W-1:0]           cnt;

  logic [rbst_pkg::Q_W:0]     num_mag;
  logic [rbst_pkg::Q_W-1:0]   den_mag;
  logic [rbst_pkg::Q_W:0]     trial;
  logic [rbst_pkg::Q_W:0]     diff;
  logic                       ge;
  logic                       big;

  assign num_mag = req.num[rbst_pkg::Q_W] ? (~req.num + 1'b1) : req.num;
  assign den_mag = req.den[rbst_pkg::Q_W-1] ? (~req.den + 1'b1) : req.den;
  assign trial   = {rem, nsh[NB_W-1]};
  assign diff    = trial - {1'b0, dmag};
  assign ge      = trial >= {1'b0, dmag};
  assign big     = ovf | q[rbst_pkg::Q_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        nsh  <= {num_mag, {FRAC_BITS{1'b0}}};
        dmag <= den_mag;
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
        zero <= (req.den == '0);
        neg  <= (req.den == '0) ? req.num[rbst_pkg::Q_W]
                                : (req.num[rbst_pkg::Q_W] ^ req.den[rbst_pkg::Q_W-1]);
        cnt  <= CNT_W'(NB_W);
        busy <= (req.den != '0);
        done <= (req.den == '0);
      end else if (busy) begin
        nsh <= {nsh[NB_W-2:0], 1'b0};
        rem <= ge ? diff[rbst_pkg::Q_W-1:0] : trial[rbst_pkg::Q_W-1:0];
        q   <= {q[rbst_pkg::Q_W-2:0], ge};
        ovf <= ovf | q[rbst_pkg::Q_W-1];
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    if (zero || big) begin
      rsp.q = neg ? rbst_pkg::Q_MIN : rbst_pkg::Q_MAX;
    end else begin
      rsp.q = neg ? -$signed(q) : $signed(q);
    end
  end

endmodule

// File: rtl/ray_box4_slab_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box4_slab_test
// Four axis-aligned boxes tested against a ray by the slab method.
// ----------------------------------------------------------------------------
// Input channel s_*: tuser carries the kind, tdata the box index and the
// first and second coordinate triples. Set and grow transactions update the
// box store on acceptance and return nothing. A ray transaction runs two
// divisions per axis per box, one after another through one bit-serial
// divider, and takes no further input until its result is registered.
// One result transaction on m_* follows each ray test; its tdata holds four
// hit bits and four entry distances.
// The result sits in an output register: while the receiver stalls, set and
// grow transactions are still taken, and a further ray test runs and then
// holds until the register is free. Unused kinds are dropped.
// Reset clears every box corner to zero and empties the output register.
// ----------------------------------------------------------------------------
module ray_box4_slab_test #(
  parameter int NUM_BOXES = rbst_pkg::DEF_NUM_BOXES,
  parameter int FRAC_BITS = rbst_pkg::DEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // box_index[1:0], first_x, first_y, first_z, second_x, second_y, second_z,
  // zero fill
  input  logic [199:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_0, hit_1, hit_2, hit_3, entry_0, entry_1, entry_2, entry_3, zero fill
  output logic [135:0] m_tdata
);

  localparam int ENTRIES = NUM_BOXES * rbst_pkg::AXES;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int TESTED  = (NUM_BOXES < rbst_pkg::REPORTED) ? NUM_BOXES
                                                            : rbst_pkg::REPORTED;
  localparam int QW      = rbst_pkg::Q_W;

  logic signed [QW-1:0] low_c  [ENTRIES];
  logic signed [QW-1:0] high_c [ENTRIES];

  logic signed [QW-1:0] org [rbst_pkg::AXES];
  logic signed [QW-1:0] dir [rbst_pkg::AXES];

  rbst_pkg::state_t   state;
  rbst_pkg::div_req_t req;
  rbst_pkg::div_rsp_t rsp;

  logic [1:0]           box_cnt;
  logic [1:0]           axis;
  logic                 side;
  logic signed [QW-1:0] t0;
  logic signed [QW-1:0] ent;
  logic signed [QW-1:0] ext;
  logic [rbst_pkg::REPORTED-1:0] hit_r;
  logic signed [QW-1:0] ent_r [rbst_pkg::REPORTED];

  logic [1:0]           in_box;
  logic                 in_acc;
  logic [IDX_W-1:0]     k;
  logic signed [QW-1:0] lo;
  logic signed [QW-1:0] hi;
  logic signed [QW-1:0] ent_next;
  logic signed [QW-1:0] ext_next;
  logic signed [QW-1:0] bound;

  assign in_box   = s_tdata[1:0];
  assign s_tready = (state == rbst_pkg::ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign k        = IDX_W'(int'(box_cnt) * rbst_pkg::AXES + int'(axis));
  assign bound    = side ? high_c[k] : low_c[k];

  always_comb begin
    req.start = (state == rbst_pkg::ST_START);
    req.num   = {bound[QW-1], bound} - {org[axis][QW-1], org[axis]};
    req.den   = dir[axis];
  end

  rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    lo       = (t0 < rsp.q) ? t0 : rsp.q;
    hi       = (t0 < rsp.q) ? rsp.q : t0;
    ent_next = (axis == 2'd0) ? rbst_pkg::Q_MIN : ent;
    ext_next = (axis == 2'd0) ? rbst_pkg::Q_MAX : ext;
    if (lo > ent_next) begin
      ent_next = lo;
    end
    if (hi < ext_next) begin
      ext_next = hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        low_c[i]  <= '0;
        high_c[i] <= '0;
      end
    end else if (in_acc && (int'(in_box) < NUM_BOXES)) begin
      for (int a = 0; a < rbst_pkg::AXES; a++) begin
        if (rbst_pkg::kind_t'(s_tuser) == rbst_pkg::KIND_SET) begin
          low_c[IDX_W'(int'(in_box) * rbst_pkg::AXES + a)]  <= s_tdata[2+QW*a +: QW];
          high_c[IDX_W'(int'(in_box) * rbst_pkg::AXES + a)] <= s_tdata[98+QW*a +: QW];
        end else if (rbst_pkg::kind_t'(s_tuser) == rbst_pkg::KIND_GROW) begin
          if ($signed(s_tdata[2+QW*a +: QW]) <
              low_c[IDX_W'(int'(in_box) * rbst_pkg::AXES + a)]) begin
            low_c[IDX_W'(int'(in_box) * rbst_pkg::AXES + a)] <= s_tdata[2+QW*a +: QW];
          end
          if ($signed(s_tdata[2+QW*a +: QW]) >
              high_c[IDX_W'(int'(in_box) * rbst_pkg::AXES + a)]) begin
            high_c[IDX_W'(int'(in_box) * rbst_pkg::AXES + a)] <= s_tdata[2+QW*a +: QW];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rbst_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      box_cnt  <= '0;
      axis     <= '0;
      side     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != rbst_pkg::ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        rbst_pkg::ST_IDLE: begin
          if (in_acc && (rbst_pkg::kind_t'(s_tuser) == rbst_pkg::KIND_RAY)) begin
            for (int a = 0; a < rbst_pkg::AXES; a++) begin
              org[a] <= s_tdata[2+QW*a +: QW];
              dir[a] <= s_tdata[98+QW*a +: QW];
            end
            for (int b = 0; b < rbst_pkg::REPORTED; b++) begin
              hit_r[b] <= 1'b0;
              ent_r[b] <= '0;
            end
            box_cnt <= '0;
            axis    <= '0;
            side    <= 1'b0;
            state   <= rbst_pkg::ST_START;
          end
        end
        rbst_pkg::ST_START: begin
          state <= rbst_pkg::ST_WAIT;
        end
        rbst_pkg::ST_WAIT: begin
          if (rsp.done) begin
            if (!side) begin
              t0    <= rsp.q;
              side  <= 1'b1;
              state <= rbst_pkg::ST_START;
            end else begin
              side <= 1'b0;
              ent  <= ent_next;
              ext  <= ext_next;
              if (axis == 2'd2) begin
                axis           <= '0;
                hit_r[box_cnt] <= (ent_next <= ext_next) &&
                                  !(ent_next[QW-1] && ext_next[QW-1]);
                ent_r[box_cnt] <= ent_next;
                if (box_cnt == 2'(TESTED - 1)) begin
                  state <= rbst_pkg::ST_DONE;
                end else begin
                  box_cnt <= box_cnt + 1'b1;
                  state   <= rbst_pkg::ST_START;
                end
              end else begin
                axis  <= axis + 1'b1;
                state <= rbst_pkg::ST_START;
              end
            end
          end
        end
        rbst_pkg::ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, ent_r[3], ent_r[2], ent_r[1], ent_r[0], hit_r};
            state    <= rbst_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= rbst_pkg::ST_IDLE;
        end
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == rbst_pkg::ST_WAIT))
    else $error("divider finished outside the wait state");

  a_wait_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == rbst_pkg::ST_WAIT) && !rsp.done) |=> (state == rbst_pkg::ST_WAIT))
    else $error("sequencer left the wait state early");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("pending result overwritten");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    ((state == rbst_pkg::ST_START) || (state == rbst_pkg::ST_WAIT)) |-> !s_tready)
    else $error("input taken during a ray test");

endmodule
